[sv/wbpt_pkg.sv]
// ----------------------------------------------------------------------------
// wbpt_pkg
// Shared types and constants of the work/break phase timer.
// ----------------------------------------------------------------------------
package wbpt_pkg;

	// Phase codes as they appear on the result channel.
	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_WORK  = 2'd1,
		PH_SHORT = 2'd2,
		PH_LONG  = 2'd3
	} phase_t;

	// Command codes of the input channel.
	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_START = 2'd1,
		CMD_PAUSE = 2'd2,
		CMD_RESET = 2'd3
	} cmd_t;

	// Configuration register indexes.
	localparam logic [1:0] REG_WORK_MIN   = 2'd0;
	localparam logic [1:0] REG_SHORT_MIN  = 2'd1;
	localparam logic [1:0] REG_LONG_MIN   = 2'd2;
	localparam logic [1:0] REG_CYCLES     = 2'd3;

	// Configuration reset values.
	localparam logic [7:0] WORK_MIN_RST   = 8'd25;
	localparam logic [7:0] SHORT_MIN_RST  = 8'd5;
	localparam logic [7:0] LONG_MIN_RST   = 8'd15;
	localparam logic [7:0] CYCLES_RST     = 8'd4;

	// Time constants. A phase lasts at most 255 minutes, which fits in 24 bits of ms.
	localparam int         DUR_W          = 24;
	localparam logic [16:0] MS_PER_MINUTE = 17'd60000;
	localparam int         DIVISOR_W      = 8;
	localparam logic [13:0] REM_SEC_MAX   = 14'd15300;

	// Milliseconds to whole seconds: ceil(2^34 / 1000) as a multiplier, then a
	// right shift by 34. The result equals floor(x / 1000) for every x below 2^24.
	localparam int          SEC_SHIFT     = 34;
	localparam int          SEC_RECIP_W   = 25;
	localparam logic [24:0] SEC_RECIP     = 25'd17179870;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic calc_dur;
		logic update;
		logic mod_start;
		logic enter_brk;
		logic calc_rem;
		logic calc_sec;
		logic load_out;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic work_expire;
		logic cycles_zero;
		logic div_done;
	} ctl_sts_t;

endpackage

[sv/wbpt_if.sv]
// ----------------------------------------------------------------------------
// wbpt_if
// Valid/ready channel interfaces of the work/break phase timer.
// ----------------------------------------------------------------------------
interface wbpt_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] now_ms;

	modport source (output valid, command, now_ms, input ready);
	modport sink   (input valid, command, now_ms, output ready);
	modport mon    (input valid, ready, command, now_ms);
endinterface

interface wbpt_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  phase;
	logic        is_paused;
	logic [13:0] remaining_seconds;
	logic [31:0] work_done_count;

	modport source (output valid, phase, is_paused, remaining_seconds, work_done_count,
		input ready);
	modport sink   (input valid, phase, is_paused, remaining_seconds, work_done_count,
		output ready);
	modport mon    (input valid, ready, phase, is_paused, remaining_seconds, work_done_count);
endinterface

interface wbpt_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[sv/wbpt_div.sv]
// ----------------------------------------------------------------------------
// wbpt_div
// Radix-2 restoring divider, one quotient bit per cycle, giving the remainder.
// ----------------------------------------------------------------------------
module wbpt_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [31:0]                    dividend,
	input  logic [wbpt_pkg::DIVISOR_W-1:0] divisor,
	output logic                           done,
	output logic [wbpt_pkg::DIVISOR_W-1:0] remainder
);
	localparam int STEPS = 32;
	localparam int CW    = $clog2(STEPS);
	localparam int DW    = wbpt_pkg::DIVISOR_W;

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [31:0]   quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;

	logic [DW:0]   shifted;
	logic          fits;
	logic [DW:0]   diff;

	assign shifted = {rem_q, quo_q[31]};
	assign fits    = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], fits};
			rem_q <= fits ? diff[DW-1:0] : shifted[DW-1:0];
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;
endmodule

[sv/wbpt_dp.sv]
// ----------------------------------------------------------------------------
// wbpt_dp
// Datapath: configuration, phase state, duration and remaining-time arithmetic.
// ----------------------------------------------------------------------------
module wbpt_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wbpt_pkg::ctl_cmd_t   cmd,
	output wbpt_pkg::ctl_sts_t   sts,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic [1:0]           in_command,
	input  logic [31:0]          in_now_ms,
	output logic [1:0]           res_phase,
	output logic                 res_is_paused,
	output logic [13:0]          res_remaining_seconds,
	output logic [31:0]          res_work_done_count
);
	localparam int DW = wbpt_pkg::DUR_W;
	localparam int PW = DW + wbpt_pkg::SEC_RECIP_W;

	logic [7:0]  work_min_q;
	logic [7:0]  short_min_q;
	logic [7:0]  long_min_q;
	logic [7:0]  cycles_q;

	wbpt_pkg::phase_t phase_q;
	logic        paused_q;
	logic [31:0] start_q;
	logic [31:0] frozen_q;
	logic [31:0] done_q;

	wbpt_pkg::cmd_t cmd_q;
	logic [31:0] now_q;
	logic [DW-1:0] dur_q;
	logic [DW-1:0] rem_q;
	logic [13:0] sec_q;

	logic [1:0]  out_phase_q;
	logic        out_paused_q;
	logic [13:0] out_sec_q;
	logic [31:0] out_done_q;

	logic [7:0]  minutes;
	logic [DW-1:0] dur_full;
	logic [31:0] elapsed_run;
	logic [31:0] elapsed_eff;
	logic        expired;
	logic        eff_expired;
	logic        long_due;
	logic [PW-1:0] sec_prod;

	logic        div_start;
	logic [31:0] div_dividend;
	logic [wbpt_pkg::DIVISOR_W-1:0] div_divisor;
	logic        div_done;
	logic [wbpt_pkg::DIVISOR_W-1:0] div_rem;

	always_comb begin
		unique case (phase_q)
			wbpt_pkg::PH_WORK:  minutes = work_min_q;
			wbpt_pkg::PH_SHORT: minutes = short_min_q;
			wbpt_pkg::PH_LONG:  minutes = long_min_q;
			default:            minutes = 8'd0;
		endcase
	end

	assign dur_full    = DW'(minutes) * DW'(wbpt_pkg::MS_PER_MINUTE);
	assign elapsed_run = now_q - start_q;
	assign expired     = elapsed_run >= 32'(dur_q);
	assign elapsed_eff = paused_q ? frozen_q : elapsed_run;
	assign eff_expired = elapsed_eff >= 32'(dur_q);
	assign long_due    = (cycles_q != 8'd0) && (div_rem == '0);
	assign sec_prod    = PW'(rem_q) * PW'(wbpt_pkg::SEC_RECIP);

	assign sts.work_expire = (cmd_q == wbpt_pkg::CMD_TICK) && (phase_q == wbpt_pkg::PH_WORK)
		&& !paused_q && expired;
	assign sts.cycles_zero = (cycles_q == 8'd0);
	assign sts.div_done    = div_done;

	// The divider only serves the long-break test on the completed count.
	assign div_start    = cmd.mod_start;
	assign div_dividend = done_q;
	assign div_divisor  = cycles_q;

	wbpt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_min_q  <= wbpt_pkg::WORK_MIN_RST;
			short_min_q <= wbpt_pkg::SHORT_MIN_RST;
			long_min_q  <= wbpt_pkg::LONG_MIN_RST;
			cycles_q    <= wbpt_pkg::CYCLES_RST;
			phase_q     <= wbpt_pkg::PH_IDLE;
			paused_q    <= 1'b0;
			start_q     <= '0;
			frozen_q    <= '0;
			done_q      <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					wbpt_pkg::REG_WORK_MIN:  work_min_q  <= cfg_data;
					wbpt_pkg::REG_SHORT_MIN: short_min_q <= cfg_data;
					wbpt_pkg::REG_LONG_MIN:  long_min_q  <= cfg_data;
					wbpt_pkg::REG_CYCLES:    cycles_q    <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.update) begin
				unique case (cmd_q)
					wbpt_pkg::CMD_TICK: begin
						if (phase_q != wbpt_pkg::PH_IDLE && !paused_q && expired) begin
							if (phase_q == wbpt_pkg::PH_WORK) begin
								// The break is entered later, after the long-break test when the interval is nonzero.
								done_q <= done_q + 32'd1;
							end else begin
								phase_q  <= wbpt_pkg::PH_WORK;
								start_q  <= now_q;
								frozen_q <= '0;
							end
						end
					end
					wbpt_pkg::CMD_START: begin
						if (phase_q == wbpt_pkg::PH_IDLE) begin
							phase_q  <= wbpt_pkg::PH_WORK;
							paused_q <= 1'b0;
							start_q  <= now_q;
							frozen_q <= '0;
						end else if (paused_q) begin
							start_q  <= now_q - frozen_q;
							paused_q <= 1'b0;
						end
					end
					wbpt_pkg::CMD_PAUSE: begin
						if (phase_q != wbpt_pkg::PH_IDLE && !paused_q) begin
							frozen_q <= elapsed_run;
							paused_q <= 1'b1;
						end
					end
					wbpt_pkg::CMD_RESET: begin
						phase_q  <= wbpt_pkg::PH_IDLE;
						paused_q <= 1'b0;
						start_q  <= '0;
						frozen_q <= '0;
						done_q   <= '0;
					end
					default: ;
				endcase
			end
			if (cmd.enter_brk) begin
				phase_q  <= long_due ? wbpt_pkg::PH_LONG : wbpt_pkg::PH_SHORT;
				paused_q <= 1'b0;
				start_q  <= now_q;
				frozen_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			cmd_q <= wbpt_pkg::cmd_t'(in_command);
			now_q <= in_now_ms;
		end
		if (cmd.calc_dur) begin
			dur_q <= dur_full;
		end
		if (cmd.calc_rem) begin
			if (phase_q == wbpt_pkg::PH_IDLE || eff_expired) begin
				rem_q <= '0;
			end else begin
				rem_q <= dur_q - elapsed_eff[DW-1:0];
			end
		end
		if (cmd.calc_sec) begin
			sec_q <= sec_prod[wbpt_pkg::SEC_SHIFT +: 14];
		end
		if (cmd.load_out) begin
			out_phase_q  <= phase_q;
			out_paused_q <= paused_q;
			out_sec_q    <= sec_q;
			out_done_q   <= done_q;
		end
	end

	assign res_phase             = out_phase_q;
	assign res_is_paused         = out_paused_q;
	assign res_remaining_seconds = out_sec_q;
	assign res_work_done_count   = out_done_q;
endmodule

[sv/wbpt_ctrl.sv]
// ----------------------------------------------------------------------------
// wbpt_ctrl
// Controller: sequences one command through the datapath and owns the handshakes.
// ----------------------------------------------------------------------------
module wbpt_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	output logic               result_valid,
	input  logic               result_ready,
	input  wbpt_pkg::ctl_sts_t sts,
	output wbpt_pkg::ctl_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE,
		S_DUR1,
		S_UPD,
		S_MOD,
		S_MOD_WAIT,
		S_ENTER,
		S_DUR2,
		S_REM,
		S_SEC,
		S_DONE
	} state_t;

	state_t state_q;
	logic   ready_q;
	logic   out_valid_q;
	logic   calc_dur_q;
	logic   update_q;
	logic   mod_start_q;
	logic   enter_brk_q;
	logic   calc_rem_q;
	logic   calc_sec_q;
	logic   load_in;
	logic   load_out;

	assign load_in  = item_valid && ready_q;
	assign load_out = (state_q == S_DONE) && (!out_valid_q || result_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ready_q     <= 1'b1;
			out_valid_q <= 1'b0;
			calc_dur_q  <= 1'b0;
			update_q    <= 1'b0;
			mod_start_q <= 1'b0;
			enter_brk_q <= 1'b0;
			calc_rem_q  <= 1'b0;
			calc_sec_q  <= 1'b0;
		end else begin
			calc_dur_q  <= 1'b0;
			update_q    <= 1'b0;
			mod_start_q <= 1'b0;
			enter_brk_q <= 1'b0;
			calc_rem_q  <= 1'b0;
			calc_sec_q  <= 1'b0;
			if (out_valid_q && result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (load_in) begin
						ready_q    <= 1'b0;
						calc_dur_q <= 1'b1;
						state_q    <= S_DUR1;
					end
				end
				S_DUR1: begin
					update_q <= 1'b1;
					state_q  <= S_UPD;
				end
				S_UPD: begin
					if (sts.work_expire && !sts.cycles_zero) begin
						mod_start_q <= 1'b1;
						state_q     <= S_MOD;
					end else if (sts.work_expire) begin
						enter_brk_q <= 1'b1;
						state_q     <= S_ENTER;
					end else begin
						calc_dur_q <= 1'b1;
						state_q    <= S_DUR2;
					end
				end
				S_MOD: begin
					state_q <= S_MOD_WAIT;
				end
				S_MOD_WAIT: begin
					if (sts.div_done) begin
						enter_brk_q <= 1'b1;
						state_q     <= S_ENTER;
					end
				end
				S_ENTER: begin
					calc_dur_q <= 1'b1;
					state_q    <= S_DUR2;
				end
				S_DUR2: begin
					calc_rem_q <= 1'b1;
					state_q    <= S_REM;
				end
				S_REM: begin
					calc_sec_q <= 1'b1;
					state_q    <= S_SEC;
				end
				S_SEC: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load_out) begin
						out_valid_q <= 1'b1;
						ready_q     <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign item_ready    = ready_q;
	assign result_valid  = out_valid_q;
	assign cmd.load_in   = load_in;
	assign cmd.calc_dur  = calc_dur_q;
	assign cmd.update    = update_q;
	assign cmd.mod_start = mod_start_q;
	assign cmd.enter_brk = enter_brk_q;
	assign cmd.calc_rem  = calc_rem_q;
	assign cmd.calc_sec  = calc_sec_q;
	assign cmd.load_out  = load_out;
endmodule

[sv/work_break_phase_timer.sv]
// ----------------------------------------------------------------------------
// work_break_phase_timer
// Pomodoro-style phase timer: Work, then a short or long break, then Work again.
// ----------------------------------------------------------------------------
// Usage. Each transaction on the item channel carries a command (tick, start or
// resume, pause, reset to idle) and the current time in milliseconds. For every
// item the block returns exactly one transaction on the result channel with the
// phase, the pause flag, the whole seconds left in the phase and the number of
// completed work phases. The cfg channel writes the four 8-bit registers (work,
// short break and long break minutes, work phases per long break); it is always
// ready and should be used only while no item is in flight.
// Processing. One item is processed at a time: the item channel closes when an item is
// accepted and opens again in the same cycle as the result becomes valid. Each item passes
// through duration lookup, state update, a second duration lookup, the remaining time and
// the seconds conversion. A tick that ends a work phase with a nonzero long-break interval
// first runs the completed count through a radix-2 modulo and then enters the break; with a
// zero interval it enters the break directly. The seconds come from a combinational
// multiplication by a reciprocal of 1000.
// Stalls. The result sits in an output register. While it waits for the
// receiver, the next item is accepted and processed; it then holds in its final
// state until the output register frees up.
// Reset. arst_n clears the phase to idle, the pause flag, both times and the
// completed count, and restores the register defaults (25, 5, 15, 4).
// ----------------------------------------------------------------------------
module work_break_phase_timer (
	input  logic                 clk,
	input  logic                 arst_n,
	wbpt_item_if.sink            item,
	wbpt_result_if.source        result,
	wbpt_cfg_if.sink             cfg
);
	wbpt_pkg::ctl_cmd_t cmd;
	wbpt_pkg::ctl_sts_t sts;

	// Register writes never stall.
	assign cfg.ready = 1'b1;

	// The controller walks each command through duration lookup, state update,
	// the optional long-break test, the remaining time and the seconds conversion.
	wbpt_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// The datapath holds the timer state, the registers and the output payload.
	wbpt_dp u_dp (
		.clk                   (clk),
		.arst_n                (arst_n),
		.cmd                   (cmd),
		.sts                   (sts),
		.cfg_we                (cfg.valid),
		.cfg_index             (cfg.index),
		.cfg_data              (cfg.data),
		.in_command            (item.command),
		.in_now_ms             (item.now_ms),
		.res_phase             (result.phase),
		.res_is_paused         (result.is_paused),
		.res_remaining_seconds (result.remaining_seconds),
		.res_work_done_count   (result.work_done_count)
	);
endmodule

[sv/wbpt_checker.sv]
// ----------------------------------------------------------------------------
// wbpt_checker
// Port-level assertions for the work/break phase timer, bound to the top level.
// ----------------------------------------------------------------------------
module wbpt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic [1:0]  result_phase,
	input logic        result_is_paused,
	input logic [13:0] result_remaining_seconds,
	input logic [31:0] result_work_done_count
);
	// One item at a time: the input closes right after a transaction.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while another was in flight");

	// Idle reports no remaining time.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_phase == wbpt_pkg::PH_IDLE
		|-> result_remaining_seconds == 14'd0)
		else $error("idle result with nonzero remaining time");

	// Idle is never paused.
	a_idle_unpaused: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_is_paused |-> result_phase != wbpt_pkg::PH_IDLE)
		else $error("paused flag set while idle");

	// No phase is longer than 255 minutes.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result_remaining_seconds <= wbpt_pkg::REM_SEC_MAX)
		else $error("remaining seconds out of range");

	// A stalled result holds.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_phase)
		&& $stable(result_is_paused) && $stable(result_remaining_seconds)
		&& $stable(result_work_done_count))
		else $error("stalled result changed");
endmodule

bind work_break_phase_timer wbpt_checker u_wbpt_checker (
	.clk                      (clk),
	.arst_n                   (arst_n),
	.item_valid               (item.valid),
	.item_ready               (item.ready),
	.result_valid             (result.valid),
	.result_ready             (result.ready),
	.result_phase             (result.phase),
	.result_is_paused         (result.is_paused),
	.result_remaining_seconds (result.remaining_seconds),
	.result_work_done_count   (result.work_done_count)
);
